// ===== rtl/pid_controller_antiwindup_core_assert.svh =====
// Assertion macros for the PID core. Each expects aclk and aresetn in scope.
// No other dependencies.
`ifndef PID_CONTROLLER_ANTIWINDUP_CORE_ASSERT_SVH
`define PID_CONTROLLER_ANTIWINDUP_CORE_ASSERT_SVH

// Same-cycle implication.
`define PIDAW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PIDAW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pidaw_pkg.sv =====
// Shared types and constants for the PID core with integral clamp.
// No dependencies.
`timescale 1ns / 1ps

package pidaw_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int DT_FLOOR_US_DEF  = 1000;
    localparam int DATA_W           = 32;
    localparam int DT_W             = 20;
    localparam int ACC_W            = 64;
    localparam int PROD_W           = 96;
    localparam int CFG_IDX_W        = 3;
    localparam int USEC_PER_SEC     = 1000000;
    localparam int LIMIT_RST_INT    = 100;
    // Smallest divider width: |err| * dt and |derr| * 1e6 both fit here.
    localparam int DIV_W_MIN        = DATA_W + DT_W;
    localparam int DIV_RADIX_BITS   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT   = 3'd0,
        REG_GAIN_P     = 3'd1,
        REG_GAIN_I     = 3'd2,
        REG_GAIN_D     = 3'd3,
        REG_LIMIT_LOW  = 3'd4,
        REG_LIMIT_HIGH = 3'd5
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_P_LO, ST_P_HI, ST_P_FIN,
        ST_S_LO, ST_S_HI, ST_S_DIV, ST_S_WAIT,
        ST_I_LO, ST_I_HI, ST_I_FIN, ST_I_CLAMP, ST_BC_WAIT,
        ST_R_LO, ST_R_HI, ST_R_DIV, ST_R_WAIT,
        ST_D_LO, ST_D_HI, ST_D_FIN,
        ST_SUM1, ST_SUM2, ST_OUT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_MUL_FIN,
        OP_DIV_STEP,
        OP_ADD_STEP,
        OP_I_CLAMP,
        OP_SAVE_BC,
        OP_DIV_RATE,
        OP_SAVE_RATE,
        OP_SUM1,
        OP_SUM2,
        OP_COMMIT
    } dp_op_t;

    typedef enum logic [2:0] {
        MSEL_P,
        MSEL_STEP,
        MSEL_I,
        MSEL_RATE,
        MSEL_D
    } mul_sel_t;

    typedef struct packed {
        dp_op_t   op;
        mul_sel_t msel;
    } dp_cmd_t;

    typedef struct packed {
        logic first;
        logic div_done;
        logic bc_need;
    } dp_status_t;

endpackage

// ===== rtl/pidaw_div.sv =====
// Iterative unsigned divider with signed result, two quotient bits a cycle.
// Depends on pidaw_pkg.
`timescale 1ns / 1ps

module pidaw_div import pidaw_pkg::*; #(
    parameter int DIV_W = DIV_W_MIN
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [DIV_W-1:0]        dividend,
    input  logic [DATA_W-1:0]       divisor,
    input  logic                    neg,
    output logic                    done,
    output logic signed [DIV_W:0]   quotient
);

    localparam int STEPS = DIV_W / DIV_RADIX_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DATA_W-1:0]    rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DATA_W-1:0]    den_reg;
    logic                 neg_reg;

    logic [DATA_W-1:0]    rem_next;
    logic [DIV_W-1:0]     quo_next;
    logic [DATA_W:0]      trial;

    // Dividend shifts out of the top of quo_reg while quotient bits enter below.
    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int k = 0; k < DIV_RADIX_BITS; k++) begin
            trial    = {rem_next, quo_next[DIV_W-1]};
            quo_next = {quo_next[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next    = DATA_W'(trial - {1'b0, den_reg});
                quo_next[0] = 1'b1;
            end else begin
                rem_next = trial[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
            neg_reg <= neg;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

// ===== rtl/pidaw_ctrl.sv =====
// Sequencer for the PID core: walks one item through the datapath steps.
// Depends on pidaw_pkg and pid_controller_antiwindup_core_assert.svh.
`timescale 1ns / 1ps
`include "pid_controller_antiwindup_core_assert.svh"

module pidaw_ctrl import pidaw_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_valid) state_next = ST_P_LO;
            ST_P_LO:    state_next = ST_P_HI;
            ST_P_HI:    state_next = ST_P_FIN;
            ST_P_FIN:   state_next = status.first ? ST_SUM1 : ST_S_LO;
            ST_S_LO:    state_next = ST_S_HI;
            ST_S_HI:    state_next = ST_S_DIV;
            ST_S_DIV:   state_next = ST_S_WAIT;
            ST_S_WAIT:  if (status.div_done) state_next = ST_I_LO;
            ST_I_LO:    state_next = ST_I_HI;
            ST_I_HI:    state_next = ST_I_FIN;
            ST_I_FIN:   state_next = ST_I_CLAMP;
            ST_I_CLAMP: state_next = status.bc_need ? ST_BC_WAIT : ST_R_LO;
            ST_BC_WAIT: if (status.div_done) state_next = ST_R_LO;
            ST_R_LO:    state_next = ST_R_HI;
            ST_R_HI:    state_next = ST_R_DIV;
            ST_R_DIV:   state_next = ST_R_WAIT;
            ST_R_WAIT:  if (status.div_done) state_next = ST_D_LO;
            ST_D_LO:    state_next = ST_D_HI;
            ST_D_HI:    state_next = ST_D_FIN;
            ST_D_FIN:   state_next = ST_SUM1;
            ST_SUM1:    state_next = ST_SUM2;
            ST_SUM2:    state_next = ST_OUT;
            ST_OUT:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.op   = OP_NONE;
        cmd.msel = MSEL_P;
        s_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd.op = OP_LOAD;
            end
            ST_P_LO:    cmd.op = OP_MUL_LO;
            ST_P_HI:    cmd.op = OP_MUL_HI;
            ST_P_FIN:   cmd.op = OP_MUL_FIN;
            ST_S_LO: begin
                cmd.op   = OP_MUL_LO;
                cmd.msel = MSEL_STEP;
            end
            ST_S_HI: begin
                cmd.op   = OP_MUL_HI;
                cmd.msel = MSEL_STEP;
            end
            ST_S_DIV:   cmd.op = OP_DIV_STEP;
            ST_S_WAIT:  if (status.div_done) cmd.op = OP_ADD_STEP;
            ST_I_LO: begin
                cmd.op   = OP_MUL_LO;
                cmd.msel = MSEL_I;
            end
            ST_I_HI: begin
                cmd.op   = OP_MUL_HI;
                cmd.msel = MSEL_I;
            end
            ST_I_FIN: begin
                cmd.op   = OP_MUL_FIN;
                cmd.msel = MSEL_I;
            end
            ST_I_CLAMP: cmd.op = OP_I_CLAMP;
            ST_BC_WAIT: if (status.div_done) cmd.op = OP_SAVE_BC;
            ST_R_LO: begin
                cmd.op   = OP_MUL_LO;
                cmd.msel = MSEL_RATE;
            end
            ST_R_HI: begin
                cmd.op   = OP_MUL_HI;
                cmd.msel = MSEL_RATE;
            end
            ST_R_DIV:   cmd.op = OP_DIV_RATE;
            ST_R_WAIT:  if (status.div_done) cmd.op = OP_SAVE_RATE;
            ST_D_LO: begin
                cmd.op   = OP_MUL_LO;
                cmd.msel = MSEL_D;
            end
            ST_D_HI: begin
                cmd.op   = OP_MUL_HI;
                cmd.msel = MSEL_D;
            end
            ST_D_FIN: begin
                cmd.op   = OP_MUL_FIN;
                cmd.msel = MSEL_D;
            end
            ST_SUM1:    cmd.op = OP_SUM1;
            ST_SUM2:    cmd.op = OP_SUM2;
            ST_OUT:     if (out_free) cmd.op = OP_COMMIT;
            default:    cmd.op = OP_NONE;
        endcase
    end

    // The result register is loaded only when the previous item has left.
    assign m_valid_next = (m_valid_reg && !m_ready) || (cmd.op == OP_COMMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `PIDAW_ASSERT_SAME(a_commit_free, cmd.op == OP_COMMIT, !m_valid_reg || m_ready, "result overwritten before it was taken")
    `PIDAW_ASSERT_SAME(a_done_in_wait, status.div_done, state_reg == ST_S_WAIT || state_reg == ST_BC_WAIT || state_reg == ST_R_WAIT, "divider finished outside a wait state")
    `PIDAW_ASSERT_NEXT(a_first_short, state_reg == ST_P_FIN && status.first, state_reg == ST_SUM1, "first item did not skip the integral and derivative")
    `PIDAW_ASSERT_NEXT(a_accept_start, s_valid && s_ready, state_reg == ST_P_LO, "accepted item did not start the sequence")

endmodule

// ===== rtl/pidaw_datapath.sv =====
// Datapath of the PID core: registers, shared 32x32 multiplier, shared divider.
// Depends on pidaw_pkg and pidaw_div.
`timescale 1ns / 1ps

module pidaw_datapath import pidaw_pkg::*; #(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int DT_FLOOR_US = DT_FLOOR_US_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic signed [DATA_W-1:0] cfg_wr_data,
    input  logic signed [DATA_W-1:0] s_measurement,
    input  logic [DT_W-1:0]          s_elapsed_us,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    output logic signed [DATA_W-1:0] drive
);

    localparam int DIV_NEED  = (DATA_W + FRAC_BITS > DIV_W_MIN) ? DATA_W + FRAC_BITS : DIV_W_MIN;
    localparam int DIV_W     = ((DIV_NEED + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS) * DIV_RADIX_BITS;
    localparam int ERR_EXT_W = DATA_W + 1;

    localparam logic signed [DATA_W-1:0] LIMIT_RST = DATA_W'(LIMIT_RST_INT << FRAC_BITS);
    localparam logic [DT_W-1:0]          DT_FLOOR  = DT_W'(DT_FLOOR_US);
    localparam logic [DATA_W-1:0]        USEC_W    = DATA_W'(USEC_PER_SEC);
    localparam logic [ACC_W-1:0]         POS_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0]         NEG_MAX   = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] ERR_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] ERR_MIN   = {1'b1, {(DATA_W-1){1'b0}}};

    function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W-1:0] s;
        s = a + b;
        if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1])
            return a[ACC_W-1] ? NEG_MAX : POS_MAX;
        return s;
    endfunction

    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
        return v[DATA_W-1] ? $unsigned(-v) : $unsigned(v);
    endfunction

    function automatic logic [ACC_W-1:0] mag64(input logic signed [ACC_W-1:0] v);
        return v[ACC_W-1] ? $unsigned(-v) : $unsigned(v);
    endfunction

    function automatic logic signed [ACC_W-1:0] clamp(input logic signed [ACC_W-1:0] v,
                                                      input logic signed [ACC_W-1:0] lo,
                                                      input logic signed [ACC_W-1:0] hi);
        priority if (v < lo) return lo;
        else if (v > hi)     return hi;
        else                 return v;
    endfunction

    // configuration
    logic signed [DATA_W-1:0] setpoint_reg, gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [DATA_W-1:0] limit_low_reg, limit_high_reg;
    // controller state
    logic signed [ACC_W-1:0]  isum_reg;
    logic signed [DATA_W-1:0] last_err_reg;
    logic                     first_reg;
    // per-item work registers
    logic signed [DATA_W-1:0] err_reg;
    logic [DT_W-1:0]          dt_reg;
    logic [PROD_W-1:0]        acc_reg;
    logic                     mneg_reg;
    logic signed [ACC_W-1:0]  p_reg, i_reg, d_reg, rate_reg, sum_reg;
    logic signed [DATA_W-1:0] drive_reg;

    logic signed [ERR_EXT_W-1:0] err_diff, derr;
    logic signed [DATA_W-1:0]    err_in;
    logic [DT_W-1:0]             dt_in;
    logic [DATA_W-1:0]           op_a, op_b_half;
    logic [ACC_W-1:0]            op_b;
    logic                        op_neg;
    logic [ACC_W-1:0]            prod;
    logic [PROD_W-1:0]           shifted;
    logic [ACC_W-1:0]            sat_lim, mag_r;
    logic signed [ACC_W-1:0]     qres;
    logic signed [ACC_W-1:0]     lo_ext, hi_ext;
    logic                        below, above, bc_need;
    logic signed [DATA_W-1:0]    bc_limit;
    logic                        div_start, div_neg, div_done;
    logic [DIV_W-1:0]            div_dividend;
    logic [DATA_W-1:0]           div_divisor;
    logic signed [DIV_W:0]       div_quot;
    logic signed [ACC_W-1:0]     quot64;

    // error saturated to 32 bits, elapsed time floored
    assign err_diff = ERR_EXT_W'(setpoint_reg) - ERR_EXT_W'(s_measurement);
    assign err_in   = (err_diff[DATA_W] != err_diff[DATA_W-1])
                      ? (err_diff[DATA_W] ? ERR_MIN : ERR_MAX) : err_diff[DATA_W-1:0];
    assign dt_in    = (s_elapsed_us < DT_FLOOR) ? DT_FLOOR : s_elapsed_us;
    assign derr     = ERR_EXT_W'(err_reg) - ERR_EXT_W'(last_err_reg);

    // multiplier operands: magnitudes, sign kept apart
    always_comb begin
        op_a   = '0;
        op_b   = '0;
        op_neg = 1'b0;
        unique case (cmd.msel)
            MSEL_P: begin
                op_a   = mag32(gain_p_reg);
                op_b   = mag64(ACC_W'(err_reg));
                op_neg = gain_p_reg[DATA_W-1] ^ err_reg[DATA_W-1];
            end
            MSEL_STEP: begin
                op_a   = mag32(err_reg);
                op_b   = ACC_W'(dt_reg);
                op_neg = err_reg[DATA_W-1];
            end
            MSEL_I: begin
                op_a   = mag32(gain_i_reg);
                op_b   = mag64(isum_reg);
                op_neg = gain_i_reg[DATA_W-1] ^ isum_reg[ACC_W-1];
            end
            MSEL_RATE: begin
                op_a   = USEC_W;
                op_b   = mag64(ACC_W'(derr));
                op_neg = derr[ERR_EXT_W-1];
            end
            MSEL_D: begin
                op_a   = mag32(gain_d_reg);
                op_b   = mag64(rate_reg);
                op_neg = gain_d_reg[DATA_W-1] ^ rate_reg[ACC_W-1];
            end
            default: begin
                op_a   = '0;
                op_b   = '0;
                op_neg = 1'b0;
            end
        endcase
    end

    assign op_b_half = (cmd.op == OP_MUL_HI) ? op_b[ACC_W-1:DATA_W] : op_b[DATA_W-1:0];
    assign prod      = op_a * op_b_half;

    // product >> FRAC_BITS, truncated toward zero, saturated to 64 bits
    assign shifted = acc_reg >> FRAC_BITS;
    assign sat_lim = mneg_reg ? NEG_MAX : POS_MAX;
    assign mag_r   = (shifted > PROD_W'(sat_lim)) ? sat_lim : shifted[ACC_W-1:0];
    assign qres    = mneg_reg ? -$signed(mag_r) : $signed(mag_r);

    // integral term clamp and back-calculation decision
    assign lo_ext   = ACC_W'(limit_low_reg);
    assign hi_ext   = ACC_W'(limit_high_reg);
    assign below    = i_reg < lo_ext;
    assign above    = i_reg > hi_ext;
    assign bc_need  = (gain_i_reg != '0) && (below || above);
    assign bc_limit = below ? limit_low_reg : limit_high_reg;

    always_comb begin
        div_start    = 1'b0;
        div_dividend = acc_reg[DIV_W-1:0];
        div_divisor  = USEC_W;
        div_neg      = mneg_reg;
        unique case (cmd.op)
            OP_DIV_STEP: div_start = 1'b1;
            OP_I_CLAMP: begin
                div_start    = bc_need;
                div_dividend = DIV_W'(mag32(bc_limit)) << FRAC_BITS;
                div_divisor  = mag32(gain_i_reg);
                div_neg      = bc_limit[DATA_W-1] ^ gain_i_reg[DATA_W-1];
            end
            OP_DIV_RATE: begin
                div_start   = 1'b1;
                div_divisor = DATA_W'(dt_reg);
            end
            default: div_start = 1'b0;
        endcase
    end

    pidaw_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .neg      (div_neg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign quot64 = ACC_W'(div_quot);

    // configuration and state kept across items
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg   <= '0;
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            limit_low_reg  <= -LIMIT_RST;
            limit_high_reg <= LIMIT_RST;
            isum_reg       <= '0;
            last_err_reg   <= '0;
            first_reg      <= 1'b1;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_reg_t'(cfg_wr_index))
                    REG_SETPOINT: begin
                        setpoint_reg <= cfg_wr_data;
                        isum_reg     <= '0;
                    end
                    REG_GAIN_P:     gain_p_reg     <= cfg_wr_data;
                    REG_GAIN_I:     gain_i_reg     <= cfg_wr_data;
                    REG_GAIN_D:     gain_d_reg     <= cfg_wr_data;
                    REG_LIMIT_LOW:  limit_low_reg  <= cfg_wr_data;
                    REG_LIMIT_HIGH: limit_high_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            unique case (cmd.op)
                OP_ADD_STEP: isum_reg <= sat_add(isum_reg, quot64);
                OP_SAVE_BC:  isum_reg <= quot64;
                OP_COMMIT: begin
                    last_err_reg <= err_reg;
                    first_reg    <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // per-item working registers
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                err_reg <= err_in;
                dt_reg  <= dt_in;
                i_reg   <= '0;
                d_reg   <= '0;
            end
            OP_MUL_LO: begin
                acc_reg  <= PROD_W'(prod);
                mneg_reg <= op_neg;
            end
            OP_MUL_HI: acc_reg <= acc_reg + {prod, {DATA_W{1'b0}}};
            OP_MUL_FIN: begin
                unique case (cmd.msel)
                    MSEL_I:  i_reg <= qres;
                    MSEL_D:  d_reg <= qres;
                    default: p_reg <= qres;
                endcase
            end
            OP_I_CLAMP:   if (bc_need) i_reg <= below ? lo_ext : hi_ext;
            OP_SAVE_RATE: rate_reg <= quot64;
            OP_SUM1:      sum_reg  <= sat_add(p_reg, i_reg);
            OP_SUM2:      sum_reg  <= sat_add(sum_reg, d_reg);
            OP_COMMIT:    drive_reg <= DATA_W'(clamp(sum_reg, lo_ext, hi_ext));
            default: ;
        endcase
    end

    assign status.first    = first_reg;
    assign status.div_done = div_done;
    assign status.bc_need  = bc_need;
    assign drive           = drive_reg;

endmodule

// ===== rtl/pid_controller_antiwindup_core.sv =====
// Top level of the PID core with integral clamp; joins pidaw_ctrl and pidaw_datapath.
// Depends on pidaw_pkg, pidaw_ctrl, pidaw_datapath (and pidaw_div below it).
//
// One item in gives one drive value out, in signed fixed point with FRAC_BITS fraction
// bits. Items are handled one at a time: the first item after reset skips the integral
// and derivative terms, later items compute all three terms, and the integral is
// back-calculated when the integral term hits a limit. The time for later items is
// set by the shared divider, which yields two quotient bits a cycle over a 52-bit
// dividend at Q16.16 (wider for FRAC_BITS above 20) and runs two or three times per
// item after the first, plus the shared 32x32 multiplier that builds each product
// from a low and a high half. A new item is accepted while a finished result still
// waits on m_ready. Configuration writes take effect at once and must only be made
// while no item is in flight; writing the setpoint clears the integral.
`timescale 1ns / 1ps

module pid_controller_antiwindup_core import pidaw_pkg::*; #(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int DT_FLOOR_US = DT_FLOOR_US_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic signed [DATA_W-1:0] cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_measurement,
    input  logic [DT_W-1:0]          s_elapsed_us,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_drive
);

    dp_cmd_t    cmd;
    dp_status_t status;

    pidaw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    pidaw_datapath #(
        .FRAC_BITS   (FRAC_BITS),
        .DT_FLOOR_US (DT_FLOOR_US)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_measurement (s_measurement),
        .s_elapsed_us  (s_elapsed_us),
        .cmd           (cmd),
        .status        (status),
        .drive         (m_drive)
    );

endmodule
